// ===== rtl/core/ipv4_lpm_pkg.sv =====
package ipv4_lpm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int PORT_BITS   = 4;
  localparam int ADDR_W      = 32;
  localparam int IDX_W       = 6;
  localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]    prefix;
    logic [ADDR_W-1:0]    netmask;
    logic [PORT_BITS-1:0] port;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [IDX_W-1:0]     index;
    logic [PORT_BITS-1:0] port;
    logic [ADDR_W-1:0]    netmask;
  } lookup_res_t;

endpackage

// ===== rtl/core/ipv4_lpm_ram.sv =====
module ipv4_lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ipv4_lpm_scan.sv =====
module ipv4_lpm_scan
  import ipv4_lpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              lookup_go,
  input  logic [ADDR_W-1:0] lookup_addr,
  output logic              busy,
  output rd_req_t           rd_req,
  input  entry_t            rd_entry,
  input  logic              rd_valid,
  output lookup_res_t       res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  localparam logic [TBL_AW-1:0] LAST_IDX = TBL_AW'(TABLE_DEPTH - 1);

  state_t               state_r, state_nxt;
  logic [TBL_AW-1:0]    cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [TBL_AW-1:0]    pend_idx_r, pend_idx_nxt;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic                 found_r, found_nxt;
  logic [TBL_AW-1:0]    best_idx_r, best_idx_nxt;
  logic [ADDR_W-1:0]    best_mask_r, best_mask_nxt;
  logic [PORT_BITS-1:0] best_port_r, best_port_nxt;
  lookup_res_t          res_r, res_nxt;
  logic                 match;
  logic                 take;

  // An entry matches when the address held for the scan and the prefix agree
  // on every mask bit.
  assign match = rd_valid && (((addr_r ^ rd_entry.prefix) & rd_entry.netmask) == '0);
  assign take  = pend_r && match && (!found_r || (rd_entry.netmask > best_mask_r));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = cnt_r;
    addr_nxt      = addr_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_mask_nxt = best_mask_r;
    best_port_nxt = best_port_r;
    res_nxt       = res_r;
    res_nxt.valid = 1'b0;
    rd_req.en     = 1'b0;
    rd_req.addr   = cnt_r;

    if (take) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = pend_idx_r;
      best_mask_nxt = rd_entry.netmask;
      best_port_nxt = rd_entry.port;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (lookup_go) begin
          state_nxt     = ST_SCAN;
          cnt_nxt       = '0;
          addr_nxt      = lookup_addr;
          found_nxt     = 1'b0;
          best_idx_nxt  = '0;
          best_mask_nxt = '0;
          best_port_nxt = '0;
        end
      end
      ST_SCAN: begin
        rd_req.en = 1'b1;
        pend_nxt  = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last entry is compared here, so the result takes the updated best.
        state_nxt       = ST_IDLE;
        res_nxt.valid   = 1'b1;
        res_nxt.hit     = found_nxt;
        res_nxt.index   = IDX_W'(best_idx_nxt);
        res_nxt.port    = best_port_nxt;
        res_nxt.netmask = best_mask_nxt;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      res_r.valid <= res_nxt.valid;
    end
    cnt_r       <= cnt_nxt;
    pend_idx_r  <= pend_idx_nxt;
    addr_r      <= addr_nxt;
    found_r     <= found_nxt;
    best_idx_r  <= best_idx_nxt;
    best_mask_r <= best_mask_nxt;
    best_port_r <= best_port_nxt;
    res_r.hit     <= res_nxt.hit;
    res_r.index   <= res_nxt.index;
    res_r.port    <= res_nxt.port;
    res_r.netmask <= res_nxt.netmask;
  end

  assign busy = (state_r != ST_IDLE);
  assign res  = res_r;

  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> !res.valid)
    else $error("result strobe held for more than one cycle");

  a_read_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_req.en |-> busy)
    else $error("table read issued outside a lookup");

  a_go_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (lookup_go && !busy) |=> (busy && cnt_r == '0))
    else $error("lookup transfer did not start a scan at entry zero");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res.hit) |-> (res.index == '0 && res.port == '0 && res.netmask == '0))
    else $error("miss result carries non-zero fields");

  a_compare_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_req.en |=> pend_r)
    else $error("table read data not compared in the next cycle");

endmodule

// ===== rtl/core/ipv4_longest_prefix_match.sv =====
// IPv4 longest-prefix-match routing table of TABLE_DEPTH entries. A transfer
// is taken when start is high and busy is low. A write (in_func = 0) stores
// one entry in a single cycle and leaves busy low, so another item may follow
// at once. A lookup (in_func = 1) reads the table memory one entry per cycle
// through its single read port and keeps busy high meanwhile; out_valid
// pulses for one cycle, registered from the scan's drain state after the
// last entry is compared, and the next item can be taken in that same
// cycle. The result must be captured while out_valid is high: it is not
// held. The table is empty after reset, with no clearing pass.
module ipv4_longest_prefix_match
  import ipv4_lpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  logic [IDX_W-1:0]     in_entry_index,
  input  logic [ADDR_W-1:0]    in_entry_prefix,
  input  logic [ADDR_W-1:0]    in_entry_netmask,
  input  logic [PORT_BITS-1:0] in_entry_port,
  input  logic                 in_entry_enable,
  input  logic [ADDR_W-1:0]    in_lookup_addr,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [IDX_W-1:0]     out_match_index,
  output logic [PORT_BITS-1:0] out_match_port,
  output logic [ADDR_W-1:0]    out_match_netmask
);

  logic                   accept;
  logic                   wr_en;
  logic [TBL_AW-1:0]      wr_addr;
  entry_t                 wr_entry;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic                   rd_valid_r;
  logic [ENTRY_W-1:0]     rd_data;
  rd_req_t                rd_req;
  lookup_res_t            res;

  assign accept   = start && !busy;
  assign wr_en    = accept && (in_func == FUNC_WRITE) &&
                    (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr  = TBL_AW'(in_entry_index);
  assign wr_entry = '{prefix: in_entry_prefix, netmask: in_entry_netmask,
                      port: in_entry_port};

  // Valid marks live in flip-flops so that reset empties the table at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= in_entry_enable;
    end
    if (rd_req.en) begin
      rd_valid_r <= valid_r[rd_req.addr];
    end
  end

  ipv4_lpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_req.en),
    .raddr (rd_req.addr),
    .rdata (rd_data)
  );

  ipv4_lpm_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_go   (accept && (in_func == FUNC_LOOKUP)),
    .lookup_addr (in_lookup_addr),
    .busy        (busy),
    .rd_req      (rd_req),
    .rd_entry    (entry_t'(rd_data)),
    .rd_valid    (rd_valid_r),
    .res         (res)
  );

  assign out_valid         = res.valid;
  assign out_hit           = res.hit;
  assign out_match_index   = res.index;
  assign out_match_port    = res.port;
  assign out_match_netmask = res.netmask;

endmodule
